/* rtl/core/length_prefixed_frame_reassembler_assert.svh */
// Assertion macros shared by the reassembler RTL.
// Each macro expects clk_i and rst_ni to be visible in the module that expands it.
`ifndef LENGTH_PREFIXED_FRAME_REASSEMBLER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lpfr_pkg.sv */
// Shared types and constants for the length-prefixed frame reassembler.
// No dependencies.
`default_nettype none

package lpfr_pkg;

  localparam int MAX_MSG_BYTES = 1024;
  localparam int ADDR_W        = $clog2(MAX_MSG_BYTES);
  localparam int CNT_W         = $clog2(MAX_MSG_BYTES + 1);
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 10;
  localparam int MSG_BYTES_W   = 11;
  localparam int HDR_W         = 16;
  // wide enough for the header length plus two and for any store count
  localparam int CMP_W         = 17;
  localparam int HDR_BYTES     = 2;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_READ     = 3'd4
  } status_e;

endpackage

`default_nettype wire

/* rtl/core/lpfr_ram.sv */
// Single-port byte store with registered read data.
// Generic; no package dependency.
`default_nettype none

module lpfr_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/length_prefixed_frame_reassembler.sv */
// Channel | Signals                                          | Direction
// input   | in_valid_i, in_stall_o, operation_i, rx_byte_i,  | into block
//         | chunk_end_i, read_index_i                        |
// output  | out_valid_o, out_stall_i, status_o,              | out of block
//         | message_bytes_o, read_data_o                     |
//
// One item per cycle unless stalled; results pass the read stage, then out register.
// Receives update count, header and flags at acceptance and write the byte store
// the same cycle; reads use the store's registered read, then an output register.
// Reset clears count and flags at once; the store needs no clearing pass.
// Input stalls only when both the read stage and the output register are held.
// Depends on lpfr_pkg, lpfr_ram and the assertion macro header.
`default_nettype none

`include "length_prefixed_frame_reassembler_assert.svh"

module length_prefixed_frame_reassembler
  import lpfr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   operation_i,
  input  wire logic [BYTE_W-1:0]      rx_byte_i,
  input  wire logic                   chunk_end_i,
  input  wire logic [IDX_W-1:0]       read_index_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  status_o,
  output logic [MSG_BYTES_W-1:0]      message_bytes_o,
  output logic [BYTE_W-1:0]           read_data_o
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_MSG_BYTES);
  localparam logic [CMP_W-1:0] MaxLen = CMP_W'(MAX_MSG_BYTES - HDR_BYTES);

  // message state
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              ready_q, ready_d;
  logic [BYTE_W-1:0] hdr_hi_q, hdr_hi_d, hdr_lo_q, hdr_lo_d;

  // read stage and output register
  logic              s1_valid_q, s1_valid_d;
  status_e           s1_status_q, s1_status_d;
  logic [CNT_W-1:0]  s1_count_q, s1_count_d;
  logic              s1_hit_q, s1_hit_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [BYTE_W-1:0] out_data_q;

  logic              accept, s1_adv, is_rx, is_rd;
  logic [CNT_W-1:0]  cnt0, cnt1;
  logic              ovf0, room, store_byte;
  logic [HDR_W-1:0]  hdr_len;
  logic              rx_result;
  status_e           rx_status;
  logic              rx_empty, rx_ready;
  logic [BYTE_W-1:0] ram_rdata;
  logic [ADDR_W-1:0] ram_addr;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_rx      = accept && (operation_i == OP_RX);
  assign is_rd      = accept && (operation_i == OP_READ);

  // receive path: drop a finished message before appending
  always_comb begin
    cnt0       = ready_q ? '0 : count_q;
    ovf0       = ready_q ? 1'b0 : ovf_q;
    room       = cnt0 < MaxCnt;
    store_byte = !ovf0 && room;
    cnt1       = store_byte ? cnt0 + CNT_W'(1) : cnt0;
    hdr_hi_d   = (store_byte && cnt0 == CNT_W'(0)) ? rx_byte_i : hdr_hi_q;
    hdr_lo_d   = (store_byte && cnt0 == CNT_W'(1)) ? rx_byte_i : hdr_lo_q;
    hdr_len    = {hdr_hi_d, hdr_lo_d};
    rx_empty   = 1'b0;
    rx_ready   = 1'b0;
    rx_status  = ST_WAIT;
    if (ovf0 || !room) begin
      rx_empty  = 1'b1;
      rx_status = ST_OVERFLOW;
    end else if (cnt1 < CNT_W'(HDR_BYTES)) begin
      rx_status = ST_WAIT;
    end else if (CMP_W'(hdr_len) > MaxLen) begin
      rx_empty  = 1'b1;
      rx_status = ST_BAD_LEN;
    end else if (CMP_W'(cnt1) >= CMP_W'(hdr_len) + CMP_W'(HDR_BYTES)) begin
      rx_ready  = 1'b1;
      rx_status = ST_COMPLETE;
    end
    rx_result = chunk_end_i;
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    ready_d = ready_q;
    if (is_rx) begin
      count_d = cnt1;
      ovf_d   = ovf0 || !room;
      ready_d = 1'b0;
      if (chunk_end_i) begin
        if (rx_empty) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
        ready_d = rx_ready;
      end
    end
  end

  always_comb begin
    s1_valid_d  = s1_adv ? 1'b0 : s1_valid_q;
    s1_status_d = s1_status_q;
    s1_count_d  = s1_count_q;
    s1_hit_d    = s1_hit_q;
    if (is_rd) begin
      s1_valid_d  = 1'b1;
      s1_status_d = ST_READ;
      s1_count_d  = count_q;
      s1_hit_d    = CMP_W'(read_index_i) < CMP_W'(count_q);
    end else if (is_rx && rx_result) begin
      s1_valid_d  = 1'b1;
      s1_status_d = rx_status;
      s1_count_d  = count_d;
      s1_hit_d    = 1'b0;
    end
  end

  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);
  assign ram_addr    = is_rd ? ADDR_W'(read_index_i) : cnt0[ADDR_W-1:0];

  lpfr_ram #(
    .DEPTH  (MAX_MSG_BYTES),
    .DATA_W (BYTE_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (is_rx && store_byte),
    .re_i    (is_rd),
    .addr_i  (ram_addr),
    .wdata_i (rx_byte_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      ready_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      ready_q     <= ready_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rx) begin
      hdr_hi_q <= hdr_hi_d;
      hdr_lo_q <= hdr_lo_d;
    end
    s1_status_q <= s1_status_d;
    s1_count_q  <= s1_count_d;
    s1_hit_q    <= s1_hit_d;
    // advance the read stage into the output register
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_q;
      out_data_q   <= (s1_status_q == ST_READ && s1_hit_q) ? ram_rdata : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign message_bytes_o = MSG_BYTES_W'(out_count_q);
  assign read_data_o     = out_data_q;

  `LPFR_ASSERT_IMP(a_count_in_range, 1'b1, count_q <= MaxCnt, "store count above capacity")
  `LPFR_ASSERT_IMP(a_ready_sane, ready_q, !ovf_q && count_q >= CNT_W'(HDR_BYTES),
                   "complete message with overflow or no header")
  `LPFR_ASSERT_NXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q,
                   "read stage lost a held item")
  `LPFR_ASSERT_IMP(a_stall_cause, in_stall_o, s1_valid_q && out_valid_q && out_stall_i,
                   "input stalled without a full pipeline")

endmodule

`default_nettype wire
